>>> hw/rtl/lru_key_value_cache_core_defines.svh
// Assertion macros used by the checker file of the cache core.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define LKVC_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define LKVC_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

>>> hw/rtl/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

  // Fixed field widths
  localparam int KEY_W   = 64;
  localparam int DATA_W  = 64;
  localparam int OCC_W   = 5;
  localparam int COUNT_W = 32;
  localparam int LIMIT_W = 5;

  // Stream packing
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_FIELD_W = DATA_W + OCC_W + 2 * COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Defaults and reset values
  localparam int CAPACITY_DEFAULT    = 16;
  localparam int VALUE_WIDTH_DEFAULT = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // Operation codes
  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } lkvc_mode_t;

  // One request as held in the input register
  typedef struct packed {
    lkvc_mode_t          mode;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
  } lkvc_req_t;

  // Lookup outcome from the entry array
  typedef struct packed {
    logic                hit;
    logic [DATA_W-1:0]   read_value;
    logic [OCC_W-1:0]    occupancy;
  } lkvc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/lru_key_value_cache_core.sv
// Fully associative LRU key/value cache core.
// A request waits in the input register until the output register takes its result.
// Throughput: one get or put per cycle unless the output stalls; the parallel key
// compare, rank and counter update all settle between the input and output registers.
// Reset (synchronous, active high): no entries valid, counters zero, limit 16;
// no clearing pass, the core accepts items in the first cycle after reset.
`default_nettype none

module lru_key_value_cache_core #(
  parameter int CAPACITY    = lkvc_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // lookup_key [63:0], data_word [127:64]
  input  wire logic [lkvc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode [0]
  input  wire logic [0:0]                       s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // read_value [63:0], occupancy [68:64], hit_total [100:69], miss_total [132:101],
  // zero [135:133]
  output logic [lkvc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // hit [0]
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [lkvc_pkg::LIMIT_W-1:0]     cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);
  import lkvc_pkg::*;

  logic [LIMIT_W-1:0] entry_limit;
  lkvc_req_t          req;
  logic               stage_valid;
  logic               out_free;
  logic               fire;
  lkvc_result_t       result;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] miss_total;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_limit <= cfg_data;
    end
  end

  // Input register: refill when empty or whenever the held item moves on
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = stage_valid && out_free;
  assign s_axis_tready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.mode <= lkvc_mode_t'(s_axis_tuser[0]);
      req.key  <= s_axis_tdata[KEY_W-1:0];
      req.data <= s_axis_tdata[KEY_W+DATA_W-1:KEY_W];
    end
  end

  lkvc_entry_array #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_entries (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req         (req),
    .entry_limit (entry_limit),
    .result      (result)
  );

  lkvc_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .is_get     (req.mode == MODE_GET),
    .hit        (result.hit),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

  // Output register: load on fire, drop valid once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tuser <= result.hit;
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, miss_total, hit_total,
                       result.occupancy, result.read_value};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_entry_array.sv
`default_nettype none

module lkvc_entry_array #(
  parameter int CAPACITY    = lkvc_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire lkvc_pkg::lkvc_req_t          req,
  input  wire logic [lkvc_pkg::LIMIT_W-1:0] entry_limit,
  output lkvc_pkg::lkvc_result_t            result
);
  import lkvc_pkg::*;

  localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Entry storage: keys and values are compared or selected in parallel
  logic [KEY_W-1:0]       keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0] values [CAPACITY];
  logic [CAPACITY-1:0]    valid;
  logic [CAPACITY-1:0]    valid_next;
  logic [RW-1:0]          rank      [CAPACITY];
  logic [RW-1:0]          rank_next [CAPACITY];
  logic [CW-1:0]          total;
  logic [CW-1:0]          total_next;

  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    victim;
  logic [CAPACITY-1:0]    free_slot;
  logic [CAPACITY-1:0]    target;
  logic                   hit_any;
  logic [RW-1:0]          hit_rank;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [RW-1:0]          last_rank;
  logic [RW-1:0]          thresh;
  logic [LW-1:0]          limit_eff;
  logic                   is_put;
  logic                   insert;
  logic                   evict;
  logic                   fill;
  logic                   do_promote;
  logic                   write_val;

  // Least recent valid entry holds rank total-1 (ranks form a permutation)
  assign last_rank = RW'(total - CW'(1));

  // Compare every entry against the key; spot the least recent one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = valid[i] && (keys[i] == req.key);
      victim[i] = valid[i] && (rank[i] == last_rank);
    end
  end

  // Lowest free slot: first zero bit of the valid vector
  assign free_slot = ~valid & (valid + CAPACITY'(1));

  // Select rank and value of the matching entry
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_rank  = hit_rank  | (rank[i]   & {RW{match[i]}});
      hit_value = hit_value | (values[i] & {VALUE_WIDTH{match[i]}});
    end
  end

  assign hit_any = |match;

  // Clamp the limit to the capacity
  assign limit_eff = (LW'(entry_limit) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(entry_limit);

  // Decide the update
  assign is_put     = (req.mode == MODE_PUT);
  assign insert     = is_put && !hit_any && (limit_eff != '0);
  assign evict      = insert && (LW'(total) >= limit_eff);
  assign fill       = insert && !evict;
  assign do_promote = hit_any || insert;
  assign write_val  = is_put && do_promote;
  assign target     = hit_any ? match : (evict ? victim : free_slot);
  assign thresh     = hit_any ? hit_rank : last_rank;

  // Move the target to most recent and age the entries that were ahead of it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rank_next[i] = rank[i];
      if (do_promote) begin
        if (target[i]) begin
          rank_next[i] = '0;
        end else if (valid[i] && (fill || (rank[i] < thresh))) begin
          rank_next[i] = rank[i] + RW'(1);
        end
      end
    end
  end

  assign valid_next = fill ? (valid | target) : valid;
  assign total_next = fill ? (total + CW'(1)) : total;

  // Result of this operation
  assign result.hit        = hit_any;
  assign result.read_value = (!is_put && hit_any) ? DATA_W'(hit_value) : '0;
  assign result.occupancy  = OCC_W'(total_next);

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      total <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= '0;
      end
    end else if (fire) begin
      valid <= valid_next;
      total <= total_next;
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  // Write key and value of the target entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (fire && target[i] && write_val) begin
        values[i] <= req.data[VALUE_WIDTH-1:0];
      end
      if (fire && target[i] && insert) begin
        keys[i] <= req.key;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_stats.sv
`default_nettype none

module lkvc_stats (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic                         is_get,
  input  wire logic                         hit,
  output logic [lkvc_pkg::COUNT_W-1:0]      hit_total,
  output logic [lkvc_pkg::COUNT_W-1:0]      miss_total
);
  import lkvc_pkg::*;

  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;

  // Saturating increments, seen by the result of the same operation
  always_comb begin
    hit_total  = hit_count;
    miss_total = miss_count;
    if (is_get && hit && (hit_count != COUNT_MAX)) begin
      hit_total = hit_count + COUNT_W'(1);
    end
    if (is_get && !hit && (miss_count != COUNT_MAX)) begin
      miss_total = miss_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count  <= '0;
      miss_count <= '0;
    end else if (fire) begin
      hit_count  <= hit_total;
      miss_count <= miss_total;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lkvc_checker.sv
`default_nettype none
`include "lru_key_value_cache_core_defines.svh"

module lkvc_checker #(
  parameter int CAPACITY = lkvc_pkg::CAPACITY_DEFAULT
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic [lkvc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]                      m_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready
);
  import lkvc_pkg::*;

  localparam int OCC_LO = DATA_W;

  // A stalled result holds
  `LKVC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A result without a hit never returns a value
  `LKVC_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[DATA_W-1:0] == '0, "nonzero value without a hit")

  // Occupancy stays within the capacity
  `LKVC_ASSERT_NOW(a_occ_bound, m_axis_tvalid, (m_axis_tdata[OCC_LO+OCC_W-1:OCC_LO] <= OCC_W'(CAPACITY)) || (CAPACITY > 31), "occupancy above capacity")

  // No result right after reset
  `LKVC_ASSERT_NOW(a_reset_empty, $past(rst), !m_axis_tvalid, "result valid right after reset")

endmodule

bind lru_key_value_cache_core lkvc_checker #(
  .CAPACITY (CAPACITY)
) u_lkvc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lkvc_pkg::*;

  localparam int CAP             = CAPACITY_DEFAULT;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_PHASES      = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int PAUSE_PHASE     = 7;

  // Output field offsets inside m_axis_tdata
  localparam int OCC_LO  = DATA_W;
  localparam int HITS_LO = DATA_W + OCC_W;
  localparam int MISS_LO = HITS_LO + COUNT_W;

  localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [KEY_W-1:0] KEY_B = 64'hfedc_ba98_7654_3210;
  localparam logic [KEY_W-1:0] KEY_C = 64'h8000_0000_0000_0001;

  typedef struct packed {
    logic               hit;
    logic [DATA_W-1:0]  read_value;
    logic [OCC_W-1:0]   occupancy;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
  } cache_resp_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]             s_axis_tuser  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [LIMIT_W-1:0]     cfg_data      = LIMIT_RESET;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;

  // Cache model state
  logic [KEY_W-1:0]   mdl_keys  [CAP];
  logic [DATA_W-1:0]  mdl_vals  [CAP];
  logic               mdl_valid [CAP];
  int unsigned        mdl_rank  [CAP];
  int unsigned        mdl_total;
  logic [COUNT_W-1:0] mdl_hits;
  logic [COUNT_W-1:0] mdl_misses;
  logic [LIMIT_W-1:0] mdl_limit;

  lkvc_req_t   req_q [$];
  cache_resp_t resp_q [$];
  lkvc_req_t   cur_req;
  cache_resp_t seen_resp;
  cache_resp_t want_resp;
  logic [KEY_W-1:0] key_pool [$];
  int          phase_limits [NUM_PHASES];
  bit          idle_en = 1'b1;
  int unsigned quiet_cycles = 0;

  int n_gets, n_puts, n_get_hits, n_evicts, n_results, n_cfg_writes, n_errors;

  lru_key_value_cache_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Make slot s most recent; valid entries more recent than rank r age by one
  function automatic void bump_to_front(int s, int unsigned r);
    for (int i = 0; i < CAP; i++) begin
      if (mdl_valid[i] && i != s && mdl_rank[i] < r) mdl_rank[i]++;
    end
    mdl_rank[s] = 0;
  endfunction

  // Apply one get or put to the model and return the response it produces
  function automatic cache_resp_t apply_request(lkvc_req_t r);
    cache_resp_t resp;
    int          slot;
    int          target;
    int unsigned worst;
    int unsigned lim;
    lim    = (mdl_limit > CAP) ? CAP : mdl_limit;
    slot   = -1;
    target = -1;
    worst  = 0;
    resp   = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (mdl_valid[i] && mdl_keys[i] == r.key) slot = i;
    end
    if (r.mode == MODE_GET) begin
      n_gets++;
      if (slot >= 0) begin
        resp.read_value = mdl_vals[slot];
        bump_to_front(slot, mdl_rank[slot]);
        n_get_hits++;
        if (mdl_hits != COUNT_MAX) mdl_hits++;
      end else if (mdl_misses != COUNT_MAX) begin
        mdl_misses++;
      end
    end else begin
      n_puts++;
      if (slot >= 0) begin
        mdl_vals[slot] = r.data;
        bump_to_front(slot, mdl_rank[slot]);
      end else if (lim > 0) begin
        if (mdl_total >= lim) begin
          // Evict the least recent entry and reuse its slot
          for (int i = 0; i < CAP; i++) begin
            if (mdl_valid[i] && (target < 0 || mdl_rank[i] > worst)) begin
              target = i;
              worst  = mdl_rank[i];
            end
          end
          if (target >= 0) begin
            bump_to_front(target, worst);
            n_evicts++;
          end
        end else begin
          // Take the lowest free slot
          for (int i = CAP - 1; i >= 0; i--) begin
            if (!mdl_valid[i]) target = i;
          end
          if (target >= 0) begin
            bump_to_front(target, CAP);
            mdl_valid[target] = 1'b1;
            mdl_total++;
          end
        end
        if (target >= 0) begin
          mdl_keys[target] = r.key;
          mdl_vals[target] = r.data;
        end
      end
    end
    resp.hit        = (slot >= 0);
    resp.occupancy  = OCC_W'(mdl_total);
    resp.hit_total  = mdl_hits;
    resp.miss_total = mdl_misses;
    return resp;
  endfunction

  function automatic void note_error(string what, cache_resp_t w, cache_resp_t g);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
      $display("  exp: hit=%0b val=%h occ=%0d hits=%0d misses=%0d",
               w.hit, w.read_value, w.occupancy, w.hit_total, w.miss_total);
      $display("  got: hit=%0b val=%h occ=%0d hits=%0d misses=%0d",
               g.hit, g.read_value, g.occupancy, g.hit_total, g.miss_total);
    end
  endfunction

  function automatic void push_req(lkvc_mode_t mode, logic [KEY_W-1:0] key,
                                   logic [DATA_W-1:0] data);
    lkvc_req_t r;
    r.mode = mode;
    r.key  = key;
    r.data = data;
    req_q.push_back(r);
  endfunction

  // Hold until every queued request has been transferred and answered
  task automatic wait_drained();
    @(negedge clk);
    while (req_q.size() != 0 || s_axis_tvalid || resp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    wait_drained();
    @(posedge clk);
    cfg_data  <= LIMIT_W'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    mdl_limit    = LIMIT_W'(v);
    n_cfg_writes++;
    @(negedge clk);
  endtask

  // Request driver: predict on each transfer, then load the next pending request
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) resp_q.push_back(apply_request(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < 8)) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= {cur_req.data, cur_req.key};
          s_axis_tuser  <= cur_req.mode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare each transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_resp.hit        = m_axis_tuser[0];
        seen_resp.read_value = m_axis_tdata[DATA_W-1:0];
        seen_resp.occupancy  = m_axis_tdata[OCC_LO +: OCC_W];
        seen_resp.hit_total  = m_axis_tdata[HITS_LO +: COUNT_W];
        seen_resp.miss_total = m_axis_tdata[MISS_LO +: COUNT_W];
        n_results++;
        if (resp_q.size() == 0) begin
          note_error("response with none pending", '0, seen_resp);
        end else begin
          want_resp = resp_q.pop_front();
          if (seen_resp.hit !== want_resp.hit ||
              seen_resp.read_value !== want_resp.read_value ||
              seen_resp.occupancy !== want_resp.occupancy ||
              seen_resp.hit_total !== want_resp.hit_total ||
              seen_resp.miss_total !== want_resp.miss_total)
            note_error("response mismatch", want_resp, seen_resp);
        end
      end
      m_axis_tready <= !(idle_en && $urandom_range(0, 99) < 8);
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("** lru_key_value_cache_core: FAILED **");
    $finish;
  end

  initial begin
    int unsigned eff;
    int unsigned pool_n;
    lkvc_req_t   r;
    for (int i = 0; i < CAP; i++) begin
      mdl_keys[i]  = '0;
      mdl_vals[i]  = '0;
      mdl_valid[i] = 1'b0;
      mdl_rank[i]  = 0;
    end
    mdl_total  = 0;
    mdl_hits   = '0;
    mdl_misses = '0;
    mdl_limit  = LIMIT_RESET;
    phase_limits = '{16, 2, 31, 0, 4, 1, 8, 16, 3, 0, 12, 20, 5, 16};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty lookup, extreme keys and values, update, ignored data on get
    push_req(MODE_GET, '0, '0);
    push_req(MODE_PUT, '0, '0);
    push_req(MODE_PUT, '1, '1);
    push_req(MODE_GET, '0, '1);
    push_req(MODE_GET, '1, {$urandom, $urandom});
    push_req(MODE_PUT, '0, 64'h5555_5555_5555_5555);
    push_req(MODE_GET, '0, '0);
    push_req(MODE_GET, KEY_A, '0);
    push_req(MODE_PUT, KEY_A, 64'haaaa_aaaa_aaaa_aaaa);

    // Limit zero: absent put stores nothing, present put still updates
    write_limit(0);
    push_req(MODE_PUT, KEY_B, 64'h1);
    push_req(MODE_PUT, KEY_A, 64'h1234);
    push_req(MODE_GET, KEY_A, '0);
    push_req(MODE_GET, KEY_B, '0);

    // Limit above capacity acts as full capacity
    write_limit(31);
    push_req(MODE_PUT, KEY_B, 64'hdead_beef_0000_ffff);
    push_req(MODE_GET, KEY_B, '0);

    // Limit below occupancy: each insert evicts one, occupancy stays
    write_limit(1);
    push_req(MODE_PUT, KEY_C, 64'h8000_0000_0000_0000);
    push_req(MODE_GET, '0, '0);
    push_req(MODE_GET, KEY_C, '0);

    // Random phases over a spread of limits, keys mostly from a small pool
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limits[p]);
      idle_en = !(p == 5 || p == 6);
      eff     = (phase_limits[p] > CAP) ? CAP : phase_limits[p];
      pool_n  = eff + $urandom_range(1, eff / 2 + 3);
      // Keep at most pool_n/2 old keys so resident keys are looked up again
      while (key_pool.size() > key_pool.size() / 2 && key_pool.size() > pool_n / 2)
        key_pool.delete(key_pool.size() - 1);
      while (key_pool.size() < pool_n) begin
        case ($urandom_range(0, 15))
          0:       key_pool.push_back('0);
          1:       key_pool.push_back('1);
          default: key_pool.push_back({$urandom, $urandom});
        endcase
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) wait_drained();
        r.mode = ($urandom_range(0, 1) != 0) ? MODE_PUT : MODE_GET;
        if ($urandom_range(0, 9) == 0)
          r.key = {$urandom, $urandom};
        else
          r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 19))
          0:       r.data = '0;
          1:       r.data = '1;
          default: r.data = {$urandom, $urandom};
        endcase
        push_req(r.mode, r.key, r.data);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d gets (%0d hits) and %0d puts with %0d evictions, %0d responses",
             n_gets, n_get_hits, n_puts, n_evicts, n_results);
    $display("over %0d limit writes spanning zero, one and above capacity", n_cfg_writes);
    if (n_errors == 0 && resp_q.size() == 0) begin
      $display("** lru_key_value_cache_core: PASSED **");
    end else begin
      if (resp_q.size() != 0) $display("%0d predicted responses never arrived", resp_q.size());
      $display("%0d response errors", n_errors);
      $display("** lru_key_value_cache_core: FAILED **");
    end
    $finish;
  end

endmodule
